### design/fat_volume_geometry_defines.svh
// ----------------------------------------------------------------------------
// FAT volume geometry assertion macros
// Concurrent assertion helpers shared by the geometry block.
// ----------------------------------------------------------------------------
`ifndef FAT_VOLUME_GEOMETRY_DEFINES_SVH
`define FAT_VOLUME_GEOMETRY_DEFINES_SVH

`ifndef SYNTHESIS
`define FVG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fat_volume_geometry: assertion failed");
`define FVG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fat_volume_geometry: implication failed");
`else
`define FVG_ASSERT(lbl, clk, rst_n, prop)
`define FVG_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif

`endif

### design/fvg_pkg.sv
// ----------------------------------------------------------------------------
// FAT volume geometry package
// Types and constants shared by the geometry pipeline.
// ----------------------------------------------------------------------------
package fvg_pkg;

  localparam logic [31:0] FAT12_LIMIT_RESET  = 32'd4084;
  localparam logic [31:0] FAT16_LIMIT_RESET  = 32'd65524;
  localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;
  localparam logic [21:0] DIR_ENTRY_BYTES    = 22'd32;

  localparam int ROOT_NUM_W = 22;
  localparam int CLUS_NUM_W = 32;

  typedef enum logic [1:0] {
    FS_UNKNOWN = 2'd0,
    FS_FAT12   = 2'd1,
    FS_FAT16   = 2'd2,
    FS_FAT32   = 2'd3
  } fs_type_t;

  typedef enum logic {
    CFG_FAT12_LIMIT = 1'b0,
    CFG_FAT16_LIMIT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        bad;
    logic [31:0] total;
    logic [39:0] fats_end;
    logic [39:0] root_off;
    logic [15:0] reserved;
    logic [7:0]  cluster_sectors;
  } div1_side_t;

  typedef struct packed {
    logic        bad;
    logic [31:0] total;
    logic [39:0] data_base;
    logic [39:0] fats_end;
    logic [39:0] root_off;
    logic [15:0] reserved;
  } div2_side_t;

endpackage

### design/fat_volume_geometry.sv
// ----------------------------------------------------------------------------
// FAT volume geometry
// Checks one FAT parameter block per beat and computes its layout and type.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Direction  Content
//   in_       in_valid / in_stall    input      parameter block fields
//   out_      out_valid / out_stall  output     status, type and geometry
//   cfg_      cfg_valid / cfg_ready  input      cluster-count limit writes
//
// One beat is taken every cycle while the output is not stalled.
// Each beat passes through two pipelined dividers of 22 and 32 stages.
// Reset clears all valid bits and loads the default cluster limits.
// A stalled result freezes the whole pipeline and in_stall follows it.
// ----------------------------------------------------------------------------
`include "fat_volume_geometry_defines.svh"

module fat_volume_geometry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sector_bytes,
  input  logic [7:0]  in_cluster_sectors,
  input  logic [15:0] in_small_total,
  input  logic [31:0] in_large_total,
  input  logic [15:0] in_reserved_sectors,
  input  logic [15:0] in_small_fat_size,
  input  logic [31:0] in_large_fat_size,
  input  logic [15:0] in_root_entries,
  input  logic [7:0]  in_fat_copies,
  input  logic [31:0] in_root_first_cluster,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status,
  output logic [1:0]  out_fs_type,
  output logic [31:0] out_sector_total,
  output logic [15:0] out_fat_start_sector,
  output logic [39:0] out_data_start_sector,
  output logic [40:0] out_root_start_sector,
  output logic [31:0] out_clusters,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  import fvg_pkg::*;

  logic        adv;
  logic [31:0] lim12_r;
  logic [31:0] lim16_r;

  logic        va_r;
  logic        bad_a_r;
  logic [31:0] total_a_r;
  logic [31:0] fat_size_a_r;
  logic [31:0] rfc_off_a_r;
  logic [21:0] num1_a_r;
  logic [15:0] den1_a_r;
  logic [15:0] reserved_a_r;
  logic [7:0]  copies_a_r;
  logic [7:0]  cs_a_r;

  logic        vb_r;
  logic        bad_b_r;
  logic [31:0] total_b_r;
  logic [39:0] fats_end_b_r;
  logic [39:0] root_off_b_r;
  logic [21:0] num1_b_r;
  logic [15:0] den1_b_r;
  logic [15:0] reserved_b_r;
  logic [7:0]  cs_b_r;

  div1_side_t        side1_in;
  div1_side_t        side1_out;
  logic [$bits(div1_side_t)-1:0] side1_vec;
  logic              v1_out;
  logic [ROOT_NUM_W-1:0] root_secs;

  logic [39:0] data_start_nxt;
  logic        total_gt;
  logic [31:0] num2_nxt;
  logic        vc_r;
  div2_side_t  side2_r;
  logic [31:0] num2_r;
  logic [7:0]  den2_r;

  div2_side_t        side2_out;
  logic [$bits(div2_side_t)-1:0] side2_vec;
  logic              v2_out;
  logic [CLUS_NUM_W-1:0] clus;

  fs_type_t    type_nxt;
  logic [40:0] root_start_nxt;

  logic        out_valid_r;
  logic        status_r;
  fs_type_t    fs_type_r;
  logic [31:0] sector_total_r;
  logic [15:0] fat_start_r;
  logic [39:0] data_start_r;
  logic [40:0] root_start_r;
  logic [31:0] clusters_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim12_r <= FAT12_LIMIT_RESET;
      lim16_r <= FAT16_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FAT12_LIMIT: lim12_r <= cfg_data;
        CFG_FAT16_LIMIT: lim16_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Field selection and the rounded-up root directory dividend.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_a_r      <= (in_sector_bytes == 16'd0) || (in_cluster_sectors == 8'd0);
      total_a_r    <= (in_small_total != 16'd0) ? 32'(in_small_total) : in_large_total;
      fat_size_a_r <= (in_small_fat_size != 16'd0) ? 32'(in_small_fat_size)
                                                   : in_large_fat_size;
      rfc_off_a_r  <= (in_root_first_cluster >= FIRST_DATA_CLUSTER)
                      ? (in_root_first_cluster - FIRST_DATA_CLUSTER) : 32'd0;
      num1_a_r     <= 22'(in_root_entries) * DIR_ENTRY_BYTES
                      + 22'(in_sector_bytes) - 22'd1;
      den1_a_r     <= in_sector_bytes;
      reserved_a_r <= in_reserved_sectors;
      copies_a_r   <= in_fat_copies;
      cs_a_r       <= in_cluster_sectors;
    end
  end

  // FAT region end and the FAT32 root offset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_b_r      <= bad_a_r;
      total_b_r    <= total_a_r;
      fats_end_b_r <= 40'(reserved_a_r) + 40'(copies_a_r) * 40'(fat_size_a_r);
      root_off_b_r <= 40'(rfc_off_a_r) * 40'(cs_a_r);
      num1_b_r     <= num1_a_r;
      den1_b_r     <= den1_a_r;
      reserved_b_r <= reserved_a_r;
      cs_b_r       <= cs_a_r;
    end
  end

  assign side1_in.bad             = bad_b_r;
  assign side1_in.total           = total_b_r;
  assign side1_in.fats_end        = fats_end_b_r;
  assign side1_in.root_off        = root_off_b_r;
  assign side1_in.reserved        = reserved_b_r;
  assign side1_in.cluster_sectors = cs_b_r;

  fvg_div_pipe #(
    .NUM_W  (ROOT_NUM_W),
    .DEN_W  (16),
    .SIDE_W ($bits(div1_side_t))
  ) u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vb_r),
    .in_num   (num1_b_r),
    .in_den   (den1_b_r),
    .in_side  (side1_in),
    .out_vld  (v1_out),
    .out_quot (root_secs),
    .out_side (side1_vec)
  );

  assign side1_out = div1_side_t'(side1_vec);

  // Data start, range check and the cluster dividend.
  assign data_start_nxt = side1_out.fats_end + 40'(root_secs);
  assign total_gt       = (40'(side1_out.total) > data_start_nxt);
  assign num2_nxt       = side1_out.total - data_start_nxt[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= v1_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r.bad       <= side1_out.bad || !total_gt;
      side2_r.total     <= side1_out.total;
      side2_r.data_base <= data_start_nxt;
      side2_r.fats_end  <= side1_out.fats_end;
      side2_r.root_off  <= side1_out.root_off;
      side2_r.reserved  <= side1_out.reserved;
      num2_r            <= num2_nxt;
      den2_r            <= side1_out.cluster_sectors;
    end
  end

  fvg_div_pipe #(
    .NUM_W  (CLUS_NUM_W),
    .DEN_W  (8),
    .SIDE_W ($bits(div2_side_t))
  ) u_clus_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (vc_r),
    .in_num   (num2_r),
    .in_den   (den2_r),
    .in_side  (side2_r),
    .out_vld  (v2_out),
    .out_quot (clus),
    .out_side (side2_vec)
  );

  assign side2_out = div2_side_t'(side2_vec);

  // Type classification and root directory start.
  always_comb begin
    if (clus <= lim12_r) begin
      type_nxt       = FS_FAT12;
      root_start_nxt = 41'(side2_out.fats_end);
    end else if (clus <= lim16_r) begin
      type_nxt       = FS_FAT16;
      root_start_nxt = 41'(side2_out.fats_end);
    end else begin
      type_nxt       = FS_FAT32;
      root_start_nxt = 41'(side2_out.data_base) + 41'(side2_out.root_off);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_out;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side2_out.bad) begin
        status_r       <= 1'b1;
        fs_type_r      <= FS_UNKNOWN;
        sector_total_r <= '0;
        fat_start_r    <= '0;
        data_start_r   <= '0;
        root_start_r   <= '0;
        clusters_r     <= '0;
      end else begin
        status_r       <= 1'b0;
        fs_type_r      <= type_nxt;
        sector_total_r <= side2_out.total;
        fat_start_r    <= side2_out.reserved;
        data_start_r   <= side2_out.data_base;
        root_start_r   <= root_start_nxt;
        clusters_r     <= clus;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_fs_type           = fs_type_r;
  assign out_sector_total      = sector_total_r;
  assign out_fat_start_sector  = fat_start_r;
  assign out_data_start_sector = data_start_r;
  assign out_root_start_sector = root_start_r;
  assign out_clusters          = clusters_r;

  `FVG_ASSERT_IMPLIES(a_err_zero, clk, rst_n, out_valid && out_status, (out_fs_type == FS_UNKNOWN) && (out_clusters == 32'd0) && (out_root_start_sector == 41'd0))
  `FVG_ASSERT_IMPLIES(a_ok_layout, clk, rst_n, out_valid && !out_status, (out_fs_type != FS_UNKNOWN) && (out_data_start_sector < 40'(out_sector_total)))
  `FVG_ASSERT(a_root_order, clk, rst_n, (out_valid && !out_status && (out_fs_type == FS_FAT32)) |-> (out_root_start_sector >= 41'(out_data_start_sector)))

endmodule

### design/fvg_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a sideband carried alongside.
// ----------------------------------------------------------------------------
module fvg_div_pipe #(
  parameter int NUM_W  = 22,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int ACC_W = DEN_W + NUM_W;

  logic [NUM_W-1:0]  vld_r;
  logic [ACC_W-1:0]  acc_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  logic [NUM_W-1:0]  vld_src;
  logic [ACC_W-1:0]  acc_src  [NUM_W];
  logic [DEN_W-1:0]  den_src  [NUM_W];
  logic [SIDE_W-1:0] side_src [NUM_W];
  logic [ACC_W-1:0]  acc_nxt  [NUM_W];

  assign vld_src[0]  = in_vld;
  assign acc_src[0]  = {{DEN_W{1'b0}}, in_num};
  assign den_src[0]  = in_den;
  assign side_src[0] = in_side;

  for (genvar g = 1; g < NUM_W; g++) begin : g_link
    assign vld_src[g]  = vld_r[g-1];
    assign acc_src[g]  = acc_r[g-1];
    assign den_src[g]  = den_r[g-1];
    assign side_src[g] = side_r[g-1];
  end

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = acc_src[g][ACC_W-1:NUM_W-1];
    assign diff  = trial - {1'b0, den_src[g]};
    assign ge    = (trial >= {1'b0, den_src[g]});
    assign acc_nxt[g] = {(ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0]),
                         acc_src[g][NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_src;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_W; i++) begin
        acc_r[i]  <= acc_nxt[i];
        den_r[i]  <= den_src[i];
        side_r[i] <= side_src[i];
      end
    end
  end

  assign out_vld  = vld_r[NUM_W-1];
  assign out_quot = acc_r[NUM_W-1][NUM_W-1:0];
  assign out_side = side_r[NUM_W-1];

endmodule
